// ----- sv/mbs_pkg.sv -----
package mbs_pkg;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_BOX_LENGTH = 1'd0;
  localparam cfg_idx_t CFG_SLOT           = 1'd1;

  localparam logic [31:0] LIMIT_RESET = 32'd99999999;

  localparam logic [31:0] CC_FTYP = 32'h6674_7970;
  localparam logic [31:0] CC_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] CC_MOOF = 32'h6D6F_6F66;
  localparam logic [31:0] CC_TRAF = 32'h7472_6166;
  localparam logic [31:0] CC_TRUN = 32'h7472_756E;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FTYP  = 2'd1;
  localparam logic [1:0] KIND_MOOV  = 2'd2;
  localparam logic [1:0] KIND_MOOF  = 2'd3;

  localparam logic [3:0] HDR_SIZE_DONE = 4'd4;
  localparam logic [3:0] HDR_DONE      = 4'd8;

  localparam logic [3:0] TRUN_SEARCH   = 4'd0;
  localparam logic [3:0] TRUN_FIRST    = 4'd1;
  localparam logic [3:0] TRUN_FLAG_POS = 4'd4;
  localparam logic [3:0] TRUN_DONE     = 4'd15;

  localparam logic [31:0] CHILD_HDR_LEN = 32'd8;
  localparam logic [31:0] SMALL_BOX_MAX = 32'd4;

endpackage

// ----- sv/mbs_if.sv -----
interface mbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface mbs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        box_start;
  logic        box_last;
  logic [1:0]  box_kind;
  logic [31:0] box_length;
  logic        first_sample;
  logic [15:0] box_slot;
  logic        error;

  modport source (
    output valid, output data_byte, output box_start, output box_last,
    output box_kind, output box_length, output first_sample, output box_slot,
    output error, input ready
  );
  modport sink (
    input valid, input data_byte, input box_start, input box_last,
    input box_kind, input box_length, input first_sample, input box_slot,
    input error, output ready
  );
endinterface

// ----- sv/mp4_box_splitter_core.sv -----
// channel   dir  handshake      word
// in_ch     in   valid/ready    in_byte, buffer_end
// out_ch    out  valid/ready    data_byte, box_start, box_last, box_kind,
//                               box_length, first_sample, box_slot, error
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// one byte accepted per clock while in_ch.ready is high; its word appears in the next
// cycle in the result register, set by the single parse step between state and result
// bytes dropped while discarding after an oversize box give no word
// reset clears all parse state, max_box_length to 99999999 and slot to 0
// in_ch.ready is low only while a held word waits on out_ch.ready
module mp4_box_splitter_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  mbs_pkg::cfg_idx_t cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  mbs_in_if.sink           in_ch,
  mbs_out_if.source        out_ch
);
  import mbs_pkg::*;

  logic [31:0] max_len_q;
  logic [15:0] slot_q;

  logic [3:0]  hc_q, hc_d;
  logic [31:0] size_q, size_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] type_q, type_d;
  logic        discard_q, discard_d;
  logic [31:0] mcr_q, mcr_d;
  logic [31:0] tcr_q, tcr_d;
  logic [63:0] ch_q, ch_d;
  logic [2:0]  chc_q, chc_d;
  logic        in_traf_q, in_traf_d;
  logic [3:0]  trun_q, trun_d;
  logic        flag_q, flag_d;

  logic        emit;
  logic        o_start, o_last, o_flag, o_err;
  logic [1:0]  o_kind;
  logic [31:0] o_length;

  logic        out_valid_q;
  logic [7:0]  data_q;
  logic        start_q, last_q, fs_q, err_q;
  logic [1:0]  kind_q;
  logic [31:0] length_q;
  logic [15:0] box_slot_q;

  logic        in_fire;
  logic [7:0]  b;

  assign b        = in_ch.in_byte;
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [31:0] size_base, size_new, type_new, type_fin, rem_new;
    logic [63:0] ch_new;
    logic        child_done;
    logic [31:0] child_size, child_type, child_rem;
    logic [31:0] mcr_n, tcr_n;
    logic [3:0]  trun_n;

    hc_d      = hc_q;
    size_d    = size_q;
    rem_d     = rem_q;
    type_d    = type_q;
    discard_d = discard_q;
    mcr_d     = mcr_q;
    tcr_d     = tcr_q;
    ch_d      = ch_q;
    chc_d     = chc_q;
    in_traf_d = in_traf_q;
    trun_d    = trun_q;
    flag_d    = flag_q;

    emit     = 1'b0;
    o_start  = 1'b0;
    o_last   = 1'b0;
    o_kind   = KIND_OTHER;
    o_length = '0;
    o_flag   = 1'b0;
    o_err    = 1'b0;

    size_base  = (hc_q == '0) ? '0 : size_q;
    size_new   = {size_base[23:0], b};
    type_new   = {type_q[23:0], b};
    rem_new    = rem_q - 32'd1;
    ch_new     = {ch_q[55:0], b};
    child_done = (chc_q == 3'd7);
    child_size = ch_new[63:32];
    child_type = ch_new[31:0];
    child_rem  = (child_size < CHILD_HDR_LEN) ? '0 : child_size - CHILD_HDR_LEN;
    mcr_n      = mcr_q - 32'd1;
    tcr_n      = tcr_q;
    trun_n     = trun_q;
    type_fin   = (hc_q < HDR_DONE) ? type_new : type_q;

    if (discard_q) begin
      if (in_ch.buffer_end) begin
        discard_d = 1'b0;
      end
    end else begin
      emit = 1'b1;
      if (hc_q < HDR_SIZE_DONE) begin
        if (hc_q == '0) begin
          o_start = 1'b1;
          type_d  = '0;
          rem_d   = '0;
        end
        size_d = size_new;
        hc_d   = hc_q + 4'd1;
        if (hc_q == HDR_SIZE_DONE - 4'd1) begin
          if (size_new > max_len_q) begin
            o_last    = 1'b1;
            o_err     = 1'b1;
            o_length  = size_new;
            hc_d      = '0;
            discard_d = !in_ch.buffer_end;
          end else if (size_new <= SMALL_BOX_MAX) begin
            o_last   = 1'b1;
            o_length = size_new;
            hc_d     = '0;
          end else begin
            rem_d = size_new - SMALL_BOX_MAX;
          end
        end
      end else begin
        rem_d = rem_new;
        if (hc_q < HDR_DONE) begin
          type_d = type_new;
          hc_d   = hc_q + 4'd1;
          if (hc_q == HDR_DONE - 4'd1) begin
            mcr_d     = '0;
            tcr_d     = '0;
            ch_d      = '0;
            chc_d     = '0;
            in_traf_d = 1'b0;
            trun_d    = TRUN_SEARCH;
            flag_d    = 1'b0;
          end
        end else if (type_q == CC_MOOF && trun_q != TRUN_DONE) begin
          if (!in_traf_q) begin
            if (mcr_q != '0) begin
              mcr_d = mcr_n;
            end else begin
              ch_d  = ch_new;
              chc_d = chc_q + 3'd1;
              if (child_done) begin
                mcr_d = child_rem;
                if (child_type == CC_TRAF) begin
                  if (child_rem == '0) begin
                    trun_d = TRUN_DONE;
                  end else begin
                    in_traf_d = 1'b1;
                    tcr_d     = '0;
                  end
                end
              end
            end
          end else begin
            mcr_d = mcr_n;
            if (trun_q != TRUN_SEARCH) begin
              if (trun_q == TRUN_FLAG_POS) begin
                flag_d = b[2];
                trun_n = TRUN_DONE;
              end else begin
                trun_n = trun_q + 4'd1;
              end
              tcr_n = tcr_q - 32'd1;
              if (trun_n != TRUN_DONE && tcr_n == '0) begin
                trun_n = TRUN_DONE;
              end
            end else if (tcr_q == '0) begin
              ch_d  = ch_new;
              chc_d = chc_q + 3'd1;
              if (child_done) begin
                tcr_n = child_rem;
                if (child_type == CC_TRUN) begin
                  trun_n = (child_rem == '0) ? TRUN_DONE : TRUN_FIRST;
                end
              end
            end else begin
              tcr_n = tcr_q - 32'd1;
            end
            if (trun_n != TRUN_DONE && mcr_n == '0) begin
              trun_n = TRUN_DONE;
            end
            tcr_d  = tcr_n;
            trun_d = trun_n;
            if (trun_n == TRUN_DONE) begin
              in_traf_d = 1'b0;
            end
          end
        end
        if (rem_new == '0) begin
          o_last   = 1'b1;
          o_length = size_q;
          if (hc_d == HDR_DONE) begin
            if (type_fin == CC_FTYP) begin
              o_kind = KIND_FTYP;
            end else if (type_fin == CC_MOOV) begin
              o_kind = KIND_MOOV;
            end else if (type_fin == CC_MOOF) begin
              o_kind = KIND_MOOF;
              o_flag = flag_d;
            end
          end
          hc_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= LIMIT_RESET;
      slot_q      <= '0;
      hc_q        <= '0;
      size_q      <= '0;
      rem_q       <= '0;
      type_q      <= '0;
      discard_q   <= 1'b0;
      mcr_q       <= '0;
      tcr_q       <= '0;
      ch_q        <= '0;
      chc_q       <= '0;
      in_traf_q   <= 1'b0;
      trun_q      <= TRUN_SEARCH;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_BOX_LENGTH: max_len_q <= cfg_data_i;
          CFG_SLOT:           slot_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        hc_q        <= hc_d;
        size_q      <= size_d;
        rem_q       <= rem_d;
        type_q      <= type_d;
        discard_q   <= discard_d;
        mcr_q       <= mcr_d;
        tcr_q       <= tcr_d;
        ch_q        <= ch_d;
        chc_q       <= chc_d;
        in_traf_q   <= in_traf_d;
        trun_q      <= trun_d;
        flag_q      <= flag_d;
        out_valid_q <= emit;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      data_q     <= b;
      start_q    <= o_start;
      last_q     <= o_last;
      kind_q     <= o_kind;
      length_q   <= o_length;
      fs_q       <= o_flag;
      box_slot_q <= slot_q;
      err_q      <= o_err;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.data_byte    = data_q;
  assign out_ch.box_start    = start_q;
  assign out_ch.box_last     = last_q;
  assign out_ch.box_kind     = kind_q;
  assign out_ch.box_length   = length_q;
  assign out_ch.first_sample = fs_q;
  assign out_ch.box_slot     = box_slot_q;
  assign out_ch.error        = err_q;

endmodule

// ----- sv/mbs_checker.sv -----
module mbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic        box_last,
  input logic [1:0]  box_kind,
  input logic [31:0] box_length,
  input logic        first_sample,
  input logic        error
);
  import mbs_pkg::*;

  // a held word stays put until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(box_length))
    else $error("held word changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && error |-> box_last && box_kind == KIND_OTHER && !first_sample)
    else $error("error word without close or with kind");

  a_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !box_last |-> box_kind == KIND_OTHER && box_length == '0 && !first_sample)
    else $error("descriptor set on a middle byte");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && first_sample |-> box_kind == KIND_MOOF)
    else $error("first_sample outside moof");

endmodule

bind mp4_box_splitter_core mbs_checker u_mbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .data_byte    (out_ch.data_byte),
  .box_last     (out_ch.box_last),
  .box_kind     (out_ch.box_kind),
  .box_length   (out_ch.box_length),
  .first_sample (out_ch.first_sample),
  .error        (out_ch.error)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import mbs_pkg::*;

  localparam logic [31:0] CC_MFHD = 32'h6D66_6864;
  localparam logic [31:0] CC_TFHD = 32'h7466_6864;
  localparam logic [31:0] CC_TFDT = 32'h7466_6474;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        box_start;
    logic        box_last;
    logic [1:0]  box_kind;
    logic [31:0] box_length;
    logic        first_sample;
    logic [15:0] box_slot;
    logic        error;
  } box_word_t;

  class box_scoreboard;
    logic [31:0] size_limit;
    logic [15:0] slot_no;
    logic [3:0]  hdr_cnt;
    logic [31:0] box_size;
    logic [31:0] box_left;
    logic [31:0] box_type;
    logic        discarding;
    logic [31:0] moof_left;
    logic [31:0] traf_left;
    logic [63:0] child_hdr;
    logic [3:0]  child_cnt;
    logic        in_traf;
    logic [3:0]  trun_pos;
    logic        first_flag;
    box_word_t   pending[$];
    int          fail_count;
    int          word_count;

    function new();
      size_limit = LIMIT_RESET;
      slot_no    = '0;
      hdr_cnt    = '0;
      box_size   = '0;
      box_left   = '0;
      box_type   = '0;
      discarding = 1'b0;
      fail_count = 0;
      word_count = 0;
      moof_open();
    endfunction

    function void moof_open();
      moof_left  = '0;
      traf_left  = '0;
      child_hdr  = '0;
      child_cnt  = '0;
      in_traf    = 1'b0;
      trun_pos   = TRUN_SEARCH;
      first_flag = 1'b0;
    endfunction

    function void set_config(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_MAX_BOX_LENGTH: size_limit = data;
        CFG_SLOT:           slot_no = data[15:0];
        default: ;
      endcase
    endfunction

    // true once a full child header has been shifted in
    function bit child_shift(logic [7:0] b, output logic [31:0] sz, output logic [31:0] cc);
      child_hdr = {child_hdr[55:0], b};
      child_cnt++;
      sz = child_hdr[63:32];
      cc = child_hdr[31:0];
      if (child_cnt < CHILD_HDR_LEN[3:0]) return 1'b0;
      child_cnt = '0;
      return 1'b1;
    endfunction

    function void moof_step(logic [7:0] b);
      logic [31:0] sz;
      logic [31:0] cc;
      logic [31:0] rem;
      if (trun_pos == TRUN_DONE) return;
      if (!in_traf) begin
        if (moof_left != 0) begin
          moof_left--;
          return;
        end
        if (!child_shift(b, sz, cc)) return;
        rem = (sz < CHILD_HDR_LEN) ? '0 : sz - CHILD_HDR_LEN;
        moof_left = rem;
        if (cc == CC_TRAF) begin
          if (rem == 0) trun_pos = TRUN_DONE;
          else begin
            in_traf   = 1'b1;
            traf_left = '0;
          end
        end
        return;
      end
      moof_left--;
      if (trun_pos != TRUN_SEARCH) begin
        if (trun_pos == TRUN_FLAG_POS) begin
          first_flag = b[2];
          trun_pos   = TRUN_DONE;
        end else begin
          trun_pos++;
        end
        traf_left--;
        if (trun_pos != TRUN_DONE && traf_left == 0) trun_pos = TRUN_DONE;
      end else if (traf_left == 0) begin
        if (child_shift(b, sz, cc)) begin
          rem = (sz < CHILD_HDR_LEN) ? '0 : sz - CHILD_HDR_LEN;
          traf_left = rem;
          if (cc == CC_TRUN) trun_pos = (rem == 0) ? TRUN_DONE : TRUN_FIRST;
        end
      end else begin
        traf_left--;
      end
      if (trun_pos != TRUN_DONE && moof_left == 0) trun_pos = TRUN_DONE;
      if (trun_pos == TRUN_DONE) in_traf = 1'b0;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      box_word_t w;
      if (discarding) begin
        if (last) discarding = 1'b0;
        return;
      end
      w = '0;
      w.data_byte = b;
      w.box_slot  = slot_no;
      if (hdr_cnt < HDR_SIZE_DONE) begin
        if (hdr_cnt == 0) begin
          w.box_start = 1'b1;
          box_size    = '0;
          box_type    = '0;
          box_left    = '0;
        end
        box_size = {box_size[23:0], b};
        hdr_cnt++;
        if (hdr_cnt == HDR_SIZE_DONE) begin
          if (box_size > size_limit) begin
            w.box_last   = 1'b1;
            w.error      = 1'b1;
            w.box_length = box_size;
            hdr_cnt      = '0;
            discarding   = !last;
          end else if (box_size <= SMALL_BOX_MAX) begin
            w.box_last   = 1'b1;
            w.box_length = box_size;
            hdr_cnt      = '0;
          end else begin
            box_left = box_size - 32'(HDR_SIZE_DONE);
          end
        end
      end else begin
        box_left--;
        if (hdr_cnt < HDR_DONE) begin
          box_type = {box_type[23:0], b};
          hdr_cnt++;
          if (hdr_cnt == HDR_DONE) moof_open();
        end else if (box_type == CC_MOOF) begin
          moof_step(b);
        end
        if (box_left == 0) begin
          w.box_last   = 1'b1;
          w.box_length = box_size;
          if (hdr_cnt == HDR_DONE) begin
            if (box_type == CC_FTYP) w.box_kind = KIND_FTYP;
            else if (box_type == CC_MOOV) w.box_kind = KIND_MOOV;
            else if (box_type == CC_MOOF) begin
              w.box_kind     = KIND_MOOF;
              w.first_sample = first_flag;
            end
          end
          hdr_cnt = '0;
        end
      end
      pending.push_back(w);
      word_count++;
    endfunction

    function void field_cmp(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        fail_count++;
      end
    endfunction

    function void check(box_word_t got);
      box_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: word %h arrived with none expected", $time, got);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      field_cmp("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      field_cmp("box_start", 32'(want.box_start), 32'(got.box_start));
      field_cmp("box_last", 32'(want.box_last), 32'(got.box_last));
      field_cmp("box_kind", 32'(want.box_kind), 32'(got.box_kind));
      field_cmp("box_length", want.box_length, got.box_length);
      field_cmp("first_sample", 32'(want.first_sample), 32'(got.first_sample));
      field_cmp("box_slot", 32'(want.box_slot), 32'(got.box_slot));
      field_cmp("error", 32'(want.error), 32'(got.error));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_t          cfg_idx_i;
  logic [31:0]       cfg_data_i;
  int                src_idle_pct;
  int                snk_idle_pct;
  int                quiet_cycles = 0;
  logic [7:0]        stream_q[$];
  box_scoreboard     sb;

  mbs_in_if  in_if ();
  mbs_out_if out_if ();

  mp4_box_splitter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    box_word_t got;
    if (rst_ni === 1'b1 && out_if.valid && out_if.ready) begin
      got.data_byte    = out_if.data_byte;
      got.box_start    = out_if.box_start;
      got.box_last     = out_if.box_last;
      got.box_kind     = out_if.box_kind;
      got.box_length   = out_if.box_length;
      got.first_sample = out_if.first_sample;
      got.box_slot     = out_if.box_slot;
      got.error        = out_if.error;
      sb.check(got);
    end
    out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.buffer_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(b, last);
  endtask

  task automatic send32(input logic [31:0] v, input logic end_on_last);
    for (int i = 3; i >= 0; i--) send_byte(v[8*i +: 8], end_on_last && i == 0);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_config(idx, data);
  endtask

  function automatic void put32(ref logic [7:0] q[$], input logic [31:0] v);
    for (int i = 3; i >= 0; i--) q.push_back(v[8*i +: 8]);
  endfunction

  // header for a body of the given length, sometimes with a bogus size
  function automatic void put_header(ref logic [7:0] q[$], input logic [31:0] cc,
                                     input int body, input bit wobble);
    logic [31:0] decl;
    decl = 32'(body + 8);
    if (wobble && $urandom_range(0, 7) == 0) decl = $urandom_range(0, body + 12);
    put32(q, decl);
    put32(q, cc);
  endfunction

  function automatic void add_box(ref logic [7:0] q[$], input logic [31:0] cc,
                                  input int body, input bit wobble);
    put_header(q, cc, body, wobble);
    repeat (body) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_moof(ref logic [7:0] q[$]);
    logic [7:0] body[$];
    logic [7:0] traf[$];
    int         ntraf;
    ntraf = ($urandom_range(0, 7) == 0) ? 0 : (($urandom_range(0, 5) == 0) ? 2 : 1);
    if ($urandom_range(0, 3) != 0) add_box(body, CC_MFHD, 8, 1'b1);
    repeat (ntraf) begin
      traf.delete();
      if ($urandom_range(0, 3) != 0) add_box(traf, CC_TFHD, $urandom_range(0, 16), 1'b1);
      if ($urandom_range(0, 7) != 0)
        add_box(traf, CC_TRUN,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 20), 1'b1);
      if ($urandom_range(0, 3) == 0) add_box(traf, CC_TFDT, $urandom_range(0, 12), 1'b1);
      put_header(body, ($urandom_range(0, 9) == 0) ? CC_TFDT : CC_TRAF, traf.size(), 1'b1);
      foreach (traf[i]) body.push_back(traf[i]);
    end
    put_header(q, CC_MOOF, body.size(), 1'b0);
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  task automatic flush_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], $urandom_range(0, 11) == 0);
    stream_q.delete();
  endtask

  // bring the parser back to a box boundary
  task automatic resync();
    while (sb.discarding || sb.hdr_cnt != 0) begin
      if (sb.discarding) send_byte(8'($urandom_range(0, 255)), 1'b1);
      else if (sb.hdr_cnt < HDR_SIZE_DONE) send_byte(8'h00, 1'($urandom_range(0, 1)));
      else send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic random_phase(input int target);
    int          sel;
    int          n;
    logic [32:0] big;
    while (sb.word_count < target) begin
      resync();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        add_moof(stream_q);
      end else if (sel < 52) begin
        add_box(stream_q, CC_FTYP, $urandom_range(0, 24), 1'b0);
      end else if (sel < 62) begin
        add_box(stream_q, CC_MOOV, $urandom_range(0, 24), 1'b0);
      end else if (sel < 76) begin
        add_box(stream_q, $urandom, $urandom_range(0, 40), 1'b0);
      end else if (sel < 84) begin
        n = $urandom_range(0, 7);
        put32(stream_q, n);
        repeat ((n > 4) ? n - 4 : 0) stream_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 92 && sb.size_limit != 32'hFFFF_FFFF) begin
        big = {1'b0, sb.size_limit} + 33'd1 + 33'($urandom_range(0, 999));
        if (big[32] || $urandom_range(0, 3) == 0) big = 33'h0_FFFF_FFFF;
        put32(stream_q, big[31:0]);
        // zero tail, so bytes left after an early buffer end parse as empty boxes
        repeat ($urandom_range(0, 8)) stream_q.push_back(8'h00);
      end else begin
        // mis-sized box of zeros, the tail lands in the next header
        put32(stream_q, $urandom_range(0, 16));
        put32(stream_q, 32'h0);
        repeat ($urandom_range(0, 8)) stream_q.push_back(8'h00);
      end
      flush_stream();
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_MAX_BOX_LENGTH;
    cfg_data_i       <= '0;
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= '0;
    in_if.buffer_end <= 1'b0;
    src_idle_pct     = 11;
    snk_idle_pct     = 79;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send32(32'h0, 1'b0);
    send32(32'h3, 1'b0);
    send32(32'h6, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send32(32'hFFFF_FFFF, 1'b1);
    send32(32'h8, 1'b0);
    send32(CC_FTYP, 1'b0);
    random_phase(350);

    wait_drained();
    write_cfg(CFG_MAX_BOX_LENGTH, 32'hFFFF_FFFF);
    write_cfg(CFG_SLOT, 32'hFFFF);
    src_idle_pct = 79;
    snk_idle_pct = 11;
    random_phase(700);

    wait_drained();
    write_cfg(CFG_MAX_BOX_LENGTH, 32'h0);
    write_cfg(CFG_SLOT, $urandom_range(1, 65534));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(760);

    wait_drained();
    write_cfg(CFG_MAX_BOX_LENGTH, 32'd64);
    write_cfg(CFG_SLOT, 32'h0);
    random_phase(1100);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/mbs_pkg.sv
sv/mbs_if.sv
sv/mp4_box_splitter_core.sv
sv/mbs_checker.sv
bench/testbench.sv
